>>> hw/rtl/glmd_pkg.sv
// Shared constants for the grid local maximum detector.
package glmd_pkg;

    localparam int MAX_GRID_DEF    = 256;
    localparam int VALUE_BITS_DEF  = 32;

    localparam int CFG_W           = 9;
    localparam int SAMPLE_W        = 32;
    localparam int PEAK_VALUE_W    = 32;
    localparam int POS_OUT_W       = 8;
    localparam int RESET_GRID_SIZE = 3;

    localparam int M_TDATA_W       = 48;
    localparam int M_TUSER_W       = 2;

    // m_tuser bit positions
    localparam int TUSER_PEAK_FOUND   = 0;
    localparam int TUSER_NONE_IN_GRID = 1;

endpackage

>>> hw/rtl/glmd_cell.sv
// One stage of the line buffer chain: loads the head beat or its left neighbor.
module glmd_cell #(
    parameter int WIDTH = 2 * glmd_pkg::VALUE_BITS_DEF
) (
    input  logic             clk,
    input  logic             shift_en,
    input  logic             load_head,
    input  logic [WIDTH-1:0] head,
    input  logic [WIDTH-1:0] prev_q,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] q_reg;
    logic [WIDTH-1:0] q_next;

    always_comb
    begin
        q_next = q_reg;
        if (shift_en)
        begin
            q_next = load_head ? head : prev_q;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

>>> hw/rtl/glmd_line_chain.sv
// Variable-length delay line of cells holding the two rows above the incoming sample.
module glmd_line_chain #(
    parameter int DEPTH  = glmd_pkg::MAX_GRID_DEF,
    parameter int WIDTH  = 2 * glmd_pkg::VALUE_BITS_DEF,
    parameter int SIZE_W = $clog2(glmd_pkg::MAX_GRID_DEF + 1)
) (
    input  logic              clk,
    input  logic              shift_en,
    input  logic [SIZE_W-1:0] size,
    input  logic [WIDTH-1:0]  head,
    output logic [WIDTH-1:0]  tap_last,
    output logic [WIDTH-1:0]  tap_ahead
);

    logic [SIZE_W-1:0] entry_idx;
    logic [WIDTH-1:0]  q [DEPTH];

    // Enter the chain so that a beat leaves the last cell exactly size beats later.
    assign entry_idx = SIZE_W'(DEPTH) - size;

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        if (k == 0)
        begin : g_first
            glmd_cell #(
                .WIDTH (WIDTH)
            ) u_cell (
                .clk       (clk),
                .shift_en  (shift_en),
                .load_head (entry_idx == SIZE_W'(k)),
                .head      (head),
                .prev_q    (head),
                .q         (q[k])
            );
        end
        else
        begin : g_next
            glmd_cell #(
                .WIDTH (WIDTH)
            ) u_cell (
                .clk       (clk),
                .shift_en  (shift_en),
                .load_head (entry_idx == SIZE_W'(k)),
                .head      (head),
                .prev_q    (q[k-1]),
                .q         (q[k])
            );
        end
    end

    assign tap_last  = q[DEPTH-1];
    assign tap_ahead = q[DEPTH-2];

endmodule

>>> hw/rtl/grid_local_maximum_detector_unit.sv
// Top level: four-neighbour strict local maximum detector over a raster-scanned square grid.
//
//   channel | dir | handshake             | payload
//   --------+-----+-----------------------+-------------------------------------------
//   s_*     | in  | s_tvalid / s_tready   | s_tdata: sample_value
//   m_*     | out | m_tvalid / m_tready   | m_tdata: peak_value, peak_row, peak_col;
//           |     |                       | m_tlast: grid_end; m_tuser: peak_found,
//           |     |                       | none_in_grid
//   cfg_*   | in  | cfg_wr_en             | cfg_wr_data: grid_size
//
// One sample per clock while s_tready is high; each yields one result beat in the next cycle.
// The line buffer is a chain of MAX_GRID cells shifted once per accepted beat.
// Reset and any grid_size write restart the grid at row 0, column 0.
// s_tready drops only while the output register holds a beat that m_tready does not take.
module grid_local_maximum_detector_unit #(
    parameter int MAX_GRID   = glmd_pkg::MAX_GRID_DEF,
    parameter int VALUE_BITS = glmd_pkg::VALUE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_wr_en,
    input  logic [glmd_pkg::CFG_W-1:0]      cfg_wr_data,  // grid_size

    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [glmd_pkg::SAMPLE_W-1:0]   s_tdata,      // [31:0] sample_value

    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [glmd_pkg::M_TDATA_W-1:0]  m_tdata,      // [31:0] peak_value, [39:32] peak_row,
                                                          // [47:40] peak_col
    output logic                            m_tlast,      // grid_end
    output logic [glmd_pkg::M_TUSER_W-1:0]  m_tuser       // [0] peak_found, [1] none_in_grid
);

    localparam int SIZE_W = $clog2(MAX_GRID + 1);
    localparam int POS_W  = $clog2(MAX_GRID);
    localparam int PAIR_W = 2 * VALUE_BITS;

    // grid geometry and scan position
    logic [SIZE_W-1:0]     size_reg,     size_next;
    logic [POS_W-1:0]      last_idx_reg, last_idx_next;
    logic [POS_W-1:0]      row_reg,      row_next;
    logic [POS_W-1:0]      col_reg,      col_next;
    logic [VALUE_BITS-1:0] left_reg,     left_next;
    logic                  any_peak_reg, any_peak_next;

    // output register
    logic                              m_valid_reg, m_valid_next;
    logic [glmd_pkg::PEAK_VALUE_W-1:0] value_reg,   value_next;
    logic [glmd_pkg::POS_OUT_W-1:0]    orow_reg,    orow_next;
    logic [glmd_pkg::POS_OUT_W-1:0]    ocol_reg,    ocol_next;
    logic                              peak_reg,    peak_next;
    logic                              end_reg,     end_next;
    logic                              none_reg,    none_next;

    logic                  s_acc;
    logic [SIZE_W-1:0]     cfg_size;
    logic [VALUE_BITS-1:0] sample;
    logic [PAIR_W-1:0]     tap_last;
    logic [PAIR_W-1:0]     tap_ahead;
    logic [VALUE_BITS-1:0] prev_c;
    logic [VALUE_BITS-1:0] second_c;
    logic [VALUE_BITS-1:0] prev_ahead;
    logic                  eval;
    logic                  peak;
    logic                  grid_last;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;

    assign sample     = VALUE_BITS'(s_tdata);
    assign prev_c     = tap_last[VALUE_BITS-1:0];
    assign second_c   = tap_last[PAIR_W-1:VALUE_BITS];
    assign prev_ahead = tap_ahead[VALUE_BITS-1:0];

    glmd_line_chain #(
        .DEPTH  (MAX_GRID),
        .WIDTH  (PAIR_W),
        .SIZE_W (SIZE_W)
    ) u_line_chain (
        .clk       (clk),
        .shift_en  (s_acc),
        .size      (size_reg),
        .head      ({prev_c, sample}),
        .tap_last  (tap_last),
        .tap_ahead (tap_ahead)
    );

    // Clamp the written size into 1..MAX_GRID.
    always_comb
    begin
        if (cfg_wr_data == '0)
        begin
            cfg_size = SIZE_W'(1);
        end
        else if (32'(cfg_wr_data) > 32'(MAX_GRID))
        begin
            cfg_size = SIZE_W'(MAX_GRID);
        end
        else
        begin
            cfg_size = SIZE_W'(cfg_wr_data);
        end
    end

    assign eval = (row_reg >= POS_W'(2)) && (col_reg >= POS_W'(1)) && (col_reg < last_idx_reg);
    assign peak = eval
                  && ($signed(prev_c) > $signed(second_c))
                  && ($signed(prev_c) > $signed(sample))
                  && ($signed(prev_c) > $signed(left_reg))
                  && ($signed(prev_c) > $signed(prev_ahead));
    assign grid_last = (row_reg == last_idx_reg) && (col_reg == last_idx_reg);

    // scan state
    always_comb
    begin
        size_next     = size_reg;
        last_idx_next = last_idx_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        left_next     = left_reg;
        any_peak_next = any_peak_reg;
        if (cfg_wr_en)
        begin
            size_next     = cfg_size;
            last_idx_next = POS_W'(cfg_size - SIZE_W'(1));
            row_next      = '0;
            col_next      = '0;
            left_next     = '0;
            any_peak_next = 1'b0;
        end
        else if (s_acc)
        begin
            if (grid_last)
            begin
                row_next      = '0;
                col_next      = '0;
                left_next     = '0;
                any_peak_next = 1'b0;
            end
            else
            begin
                left_next     = prev_c;
                any_peak_next = any_peak_reg || peak;
                if (col_reg == last_idx_reg)
                begin
                    col_next = '0;
                    row_next = row_reg + POS_W'(1);
                end
                else
                begin
                    col_next = col_reg + POS_W'(1);
                end
            end
        end
    end

    // result beat
    always_comb
    begin
        m_valid_next = m_valid_reg;
        value_next   = value_reg;
        orow_next    = orow_reg;
        ocol_next    = ocol_reg;
        peak_next    = peak_reg;
        end_next     = end_reg;
        none_next    = none_reg;
        if (s_acc)
        begin
            m_valid_next = 1'b1;
            value_next   = eval ? glmd_pkg::PEAK_VALUE_W'(prev_c) : '0;
            orow_next    = eval ? glmd_pkg::POS_OUT_W'(row_reg - POS_W'(1)) : '0;
            ocol_next    = eval ? glmd_pkg::POS_OUT_W'(col_reg) : '0;
            peak_next    = peak;
            end_next     = grid_last;
            none_next    = grid_last && !(any_peak_reg || peak);
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg     <= SIZE_W'(glmd_pkg::RESET_GRID_SIZE);
            last_idx_reg <= POS_W'(glmd_pkg::RESET_GRID_SIZE - 1);
            row_reg      <= '0;
            col_reg      <= '0;
            left_reg     <= '0;
            any_peak_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            size_reg     <= size_next;
            last_idx_reg <= last_idx_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            left_reg     <= left_next;
            any_peak_reg <= any_peak_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        orow_reg  <= orow_next;
        ocol_reg  <= ocol_next;
        peak_reg  <= peak_next;
        end_reg   <= end_next;
        none_reg  <= none_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {ocol_reg, orow_reg, value_reg};
    assign m_tlast  = end_reg;

    always_comb
    begin
        m_tuser = '0;
        m_tuser[glmd_pkg::TUSER_PEAK_FOUND]   = peak_reg;
        m_tuser[glmd_pkg::TUSER_NONE_IN_GRID] = none_reg;
    end

`ifndef ASSERT_OFF
    a_pos_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        (col_reg <= last_idx_reg) && (row_reg <= last_idx_reg))
        else $error("scan position beyond grid");

    a_beat_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc |=> m_tvalid)
        else $error("accepted sample produced no result beat");

    a_none_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[glmd_pkg::TUSER_NONE_IN_GRID] |-> m_tlast)
        else $error("none_in_grid without grid_end");

    a_peak_interior: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[glmd_pkg::TUSER_PEAK_FOUND]
            |-> (ocol_reg != '0) && !(m_tlast && m_tuser[glmd_pkg::TUSER_NONE_IN_GRID]))
        else $error("peak reported on border or with none_in_grid");
`endif

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the grid local maximum detector, with its own peak predictor.
module tb_top;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PRINT_CAP   = 40;
    localparam int MID_GRID    = 40;
    localparam int RAND_BUDGET = 60;

    typedef struct packed {
        logic                              found;
        logic [glmd_pkg::PEAK_VALUE_W-1:0] value;
        logic [glmd_pkg::POS_OUT_W-1:0]    row;
        logic [glmd_pkg::POS_OUT_W-1:0]    col;
        logic                              last;
        logic                              none;
    } peak_beat_t;

    typedef enum int {
        VALUES_FULL_RANGE,
        VALUES_NARROW,
        VALUES_EXTREMES
    } value_style_t;

    logic                            clk;
    logic                            rst_n       = 1'b0;
    logic                            cfg_wr_en   = 1'b0;
    logic [glmd_pkg::CFG_W-1:0]      cfg_wr_data = '0;
    logic                            s_tvalid    = 1'b0;
    logic                            s_tready;
    logic [glmd_pkg::SAMPLE_W-1:0]   s_tdata     = '0;
    logic                            m_tvalid;
    logic                            m_tready    = 1'b0;
    logic [glmd_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                            m_tlast;
    logic [glmd_pkg::M_TUSER_W-1:0]  m_tuser;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int mismatches     = 0;
    int beats_checked  = 0;
    int peaks_seen     = 0;
    int grids_closed   = 0;
    int cycle_count    = 0;

    // predictor state
    logic [glmd_pkg::CFG_W-1:0]           grid_cfg = glmd_pkg::CFG_W'(glmd_pkg::RESET_GRID_SIZE);
    logic signed [glmd_pkg::SAMPLE_W-1:0] row_above     [glmd_pkg::MAX_GRID_DEF];
    logic signed [glmd_pkg::SAMPLE_W-1:0] row_two_above [glmd_pkg::MAX_GRID_DEF];
    logic signed [glmd_pkg::SAMPLE_W-1:0] left_val      = '0;
    int                                   next_row      = 0;
    int                                   next_col      = 0;
    logic                                 peak_in_grid  = 1'b0;

    peak_beat_t peak_q[$];

    grid_local_maximum_detector_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, peak_q.size());
            $display("FAIL grid_local_maximum_detector_unit");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("ERROR [%0t] beat %0d: %s", $time, beats_checked, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    function automatic void restart_grid();
        next_row     = 0;
        next_col     = 0;
        peak_in_grid = 1'b0;
        left_val     = '0;
    endfunction

    // Evaluate the centre one row above the incoming sample, then shift the row stores.
    function automatic peak_beat_t predict_peak(input logic signed [glmd_pkg::SAMPLE_W-1:0] s);
        int                                   n;
        int                                   r;
        int                                   c;
        logic signed [glmd_pkg::SAMPLE_W-1:0] centre;
        peak_beat_t                           b;
        n = (grid_cfg == 0) ? 1 :
            (grid_cfg > glmd_pkg::MAX_GRID_DEF) ? glmd_pkg::MAX_GRID_DEF : int'(grid_cfg);
        r = next_row;
        c = next_col;
        b = '0;
        if (r >= 2 && c >= 1 && c + 1 < n)
        begin
            centre  = row_above[c];
            b.value = centre;
            b.row   = glmd_pkg::POS_OUT_W'(r - 1);
            b.col   = glmd_pkg::POS_OUT_W'(c);
            b.found = (centre > row_two_above[c]) && (centre > s) &&
                      (centre > left_val) && (centre > row_above[c + 1]);
        end
        left_val         = row_above[c];
        row_two_above[c] = row_above[c];
        row_above[c]     = s;
        if (b.found)
            peak_in_grid = 1'b1;
        b.last = (r == n - 1) && (c == n - 1);
        b.none = b.last && !peak_in_grid;
        if (b.last)
            restart_grid();
        else
        begin
            next_col = c + 1;
            if (next_col >= n)
            begin
                next_col = 0;
                next_row = r + 1;
            end
        end
        return b;
    endfunction

    // Check the outgoing beat first, then predict the incoming one.
    always @(posedge clk)
    begin : scoreboard
        peak_beat_t want;
        peak_beat_t got;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.found = m_tuser[glmd_pkg::TUSER_PEAK_FOUND];
                got.value = m_tdata[31:0];
                got.row   = m_tdata[39:32];
                got.col   = m_tdata[47:40];
                got.last  = m_tlast;
                got.none  = m_tuser[glmd_pkg::TUSER_NONE_IN_GRID];
                if (peak_q.size() == 0)
                    report_mismatch("result beat with no sample waiting for it");
                else
                begin
                    want = peak_q.pop_front();
                    check_field("peak_found", 32'(got.found), 32'(want.found));
                    check_field("peak_value", got.value, want.value);
                    check_field("peak_row", 32'(got.row), 32'(want.row));
                    check_field("peak_col", 32'(got.col), 32'(want.col));
                    check_field("grid_end", 32'(got.last), 32'(want.last));
                    check_field("none_in_grid", 32'(got.none), 32'(want.none));
                    if (want.found)
                        peaks_seen++;
                    if (want.last)
                        grids_closed++;
                end
                beats_checked++;
            end
            if (cfg_wr_en)
            begin
                grid_cfg = cfg_wr_data;
                restart_grid();
            end
            if (s_tvalid && s_tready)
                peak_q.push_back(predict_peak(s_tdata));
        end
    end

    function automatic logic [glmd_pkg::SAMPLE_W-1:0] pick_value(input value_style_t style);
        logic [glmd_pkg::SAMPLE_W-1:0] v;
        case (style)
            VALUES_NARROW:
            begin
                v = $urandom_range(8);
                v = v - 32'd4;
            end
            VALUES_EXTREMES:
                case ($urandom_range(5))
                    0:       v = 32'h7FFF_FFFF;
                    1:       v = 32'h8000_0000;
                    2:       v = 32'h0000_0000;
                    3:       v = 32'hFFFF_FFFF;
                    4:       v = 32'h0000_0001;
                    default: v = $urandom;
                endcase
            default:
                v = $urandom;
        endcase
        return v;
    endfunction

    // Entered just after a rising edge; returns just after the edge that takes the beat.
    task automatic send_sample(input logic [glmd_pkg::SAMPLE_W-1:0] v);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (peak_q.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_grid_size(input logic [glmd_pkg::CFG_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic send_values(input logic [glmd_pkg::SAMPLE_W-1:0] vals[9]);
        foreach (vals[i])
            send_sample(vals[i]);
    endtask

    // Reset size of 3: one extreme peak, one tie, then the sizes without an interior.
    task automatic test_directed();
        logic [glmd_pkg::SAMPLE_W-1:0] peak_grid[9];
        logic [glmd_pkg::SAMPLE_W-1:0] tie_grid[9];
        peak_grid = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        tie_grid  = '{32'd0, 32'd5, 32'd0,
                      32'd0, 32'd5, 32'd0,
                      32'd0, 32'd0, 32'd0};
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        for (int i = 0; i < 9; i++)
        begin
            // hold the source until everything in flight has come back
            if (i == 4)
                drain_results();
            send_sample(peak_grid[i]);
        end
        send_values(tie_grid);
        drain_results();
        write_grid_size(glmd_pkg::CFG_W'(0));
        send_sample(32'h1234_5678);
        send_sample(32'hFFFF_FFFF);
        drain_results();
        write_grid_size(glmd_pkg::CFG_W'(1));
        send_sample(32'h7FFF_FFFF);
        drain_results();
        write_grid_size(glmd_pkg::CFG_W'(2));
        send_sample(32'd1);
        send_sample(32'd9);
        send_sample(32'hFFFF_FFF0);
        send_sample(32'd3);
        drain_results();
    endtask

    // Oversized write cut off after a few beats, then a wide grid run for three rows and six samples more.
    task automatic test_large_grids();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        write_grid_size(glmd_pkg::CFG_W'(511));
        for (int i = 0; i < 20; i++)
            send_sample(pick_value(i[0] ? VALUES_FULL_RANGE : VALUES_NARROW));
        drain_results();
        write_grid_size(glmd_pkg::CFG_W'(MID_GRID));
        for (int i = 0; i < 3 * MID_GRID + 6; i++)
            send_sample(pick_value(VALUES_NARROW));
        drain_results();
    endtask

    // Whole grids back to back with random content; some cut short by a size write.
    task automatic test_random_grids(input int src_pct, input int sink_pct, input int budget);
        int                         sent;
        int                         n;
        int                         count;
        int                         pause_at;
        logic [glmd_pkg::CFG_W-1:0] size_w;
        value_style_t               style;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        sent           = 0;
        while (sent < budget)
        begin
            case ($urandom_range(19))
                0:       size_w = glmd_pkg::CFG_W'($urandom_range(2));
                1, 2:    size_w = glmd_pkg::CFG_W'($urandom_range(16, 9));
                default: size_w = glmd_pkg::CFG_W'($urandom_range(8, 3));
            endcase
            n     = (size_w == 0) ? 1 : int'(size_w);
            count = n * n * $urandom_range(3, 1);
            if (n > 1 && $urandom_range(5) == 0)
                count = $urandom_range(count - 1, 1);
            if (count > budget - sent)
                count = budget - sent;
            case ($urandom_range(3))
                0:       style = VALUES_FULL_RANGE;
                1:       style = VALUES_EXTREMES;
                default: style = VALUES_NARROW;
            endcase
            pause_at = ($urandom_range(7) == 0) ? $urandom_range(count - 1) : -1;
            drain_results();
            write_grid_size(size_w);
            for (int i = 0; i < count; i++)
            begin
                if (i == pause_at)
                    drain_results();
                send_sample(pick_value(style));
            end
            sent += count;
        end
        drain_results();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_large_grids();
        test_random_grids(0, 0, RAND_BUDGET);
        test_random_grids(69, 0, RAND_BUDGET);
        test_random_grids(0, 69, RAND_BUDGET);
        test_random_grids(23, 23, RAND_BUDGET);

        drain_results();
        repeat (8) @(posedge clk);

        $display("Checked %0d result beats: %0d peaks, %0d complete grids", beats_checked,
                 peaks_seen, grids_closed);
        $display("Grid sizes 0 to 16 and 40, an oversized write, restarts mid-grid, %s",
                 "source gaps and sink stalls");
        if (mismatches == 0 && peak_q.size() == 0)
            $display("PASS grid_local_maximum_detector_unit");
        else
            $display("FAIL grid_local_maximum_detector_unit");
        $finish;
    end

endmodule
